// ----- src/pcgh_pkg.sv -----
// Shared types, constants and codes of the point cloud height grid.
package pcgh_pkg;

  localparam int MAX_POINTS = 4096;
  localparam int PT_AW      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int GRID_CELLS = 64;
  localparam int CELL_AW    = $clog2(GRID_CELLS);
  localparam int GRID_W     = $clog2(GRID_CELLS + 1);

  localparam int COORD_W   = 32;
  localparam int PT_DW     = 3 * COORD_W;
  localparam int CFG_W     = 12;
  localparam int STEP_W    = 11;
  localparam int CFG_IDX_W = 3;
  localparam int SPAN_W    = CFG_W + 1;

  localparam int DIV_NW    = 57;
  localparam int DIV_MW    = DIV_NW - 1;
  localparam int DIV_DW    = 32;
  localparam int DIV_CNT_W = $clog2(DIV_MW);

  localparam int PROD_W  = COORD_W + 1 + SPAN_W;
  localparam int Q_W     = 21;
  localparam int NH_W    = 22;
  localparam int SUM_W   = 32;
  localparam int CELL_DW = SUM_W + CNT_W;
  localparam int AVG_W   = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_X_LOW  = 3'd0,
    CFG_GRID_X_HIGH = 3'd1,
    CFG_GRID_Z_LOW  = 3'd2,
    CFG_GRID_Z_HIGH = 3'd3,
    CFG_HEIGHT_LOW  = 3'd4,
    CFG_HEIGHT_HIGH = 3'd5,
    CFG_CELL_STEP   = 3'd6
  } cfg_index_t;

  typedef enum logic [14:0] {
    S_CLEAR      = 15'b000000000000001,
    S_IDLE       = 15'b000000000000010,
    S_COLS       = 15'b000000000000100,
    S_ROWS       = 15'b000000000001000,
    S_RCLAMP     = 15'b000000000010000,
    S_PT_READ    = 15'b000000000100000,
    S_PT_LATCH   = 15'b000000001000000,
    S_MUL        = 15'b000000010000000,
    S_NDIV       = 15'b000000100000000,
    S_BINX       = 15'b000001000000000,
    S_BINZ       = 15'b000010000000000,
    S_ACC_READ   = 15'b000100000000000,
    S_ACC_WRITE  = 15'b001000000000000,
    S_EMIT_READ  = 15'b010000000000000,
    S_EMIT_DIV   = 15'b100000000000000
  } state_t;

  typedef struct packed {
    logic                     start;
    logic signed [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DIV_NW-1:0] quotient;
  } div_rsp_t;

endpackage

// ----- src/pcgh_ram.sv -----
// Generic single-port RAM with registered read data.
module pcgh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- src/pcgh_div.sv -----
// Shared restoring divider, one quotient bit per cycle, truncating toward zero.
module pcgh_div import pcgh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                  active;
  logic                  done;
  logic                  neg;
  logic [DIV_CNT_W-1:0]  iter;
  logic [DIV_DW-1:0]     rem;
  logic [DIV_DW-1:0]     den;
  logic [DIV_MW-1:0]     quo;
  logic [DIV_NW-1:0]     mag;
  logic [DIV_DW:0]       shifted;
  logic [DIV_DW:0]       diff;
  logic                  fits;

  assign mag     = req.dividend[DIV_NW-1] ? DIV_NW'(-req.dividend) : DIV_NW'(req.dividend);
  assign shifted = {rem, quo[DIV_MW-1]};
  assign fits    = shifted >= {1'b0, den};
  assign diff    = shifted - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        active <= 1'b1;
        iter   <= '0;
        rem    <= '0;
        den    <= req.divisor;
        neg    <= req.dividend[DIV_NW-1];
        quo    <= mag[DIV_MW-1:0];
      end else if (active) begin
        if (fits) begin
          rem <= diff[DIV_DW-1:0];
          quo <= {quo[DIV_MW-2:0], 1'b1};
        end else begin
          rem <= shifted[DIV_DW-1:0];
          quo <= {quo[DIV_MW-2:0], 1'b0};
        end
        if (iter == DIV_CNT_W'(DIV_MW - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
        iter <= iter + 1'b1;
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

endmodule

// ----- src/point_cloud_grid_height_average.sv -----
// Point cloud height grid: load words are accepted back to back while idle.
// A finish word runs its divisions one after another on the shared divider: at most five
// per point, one per non-empty cell and three to size the grid.
// Each result word is strobed for one cycle, with gaps between; the receiver cannot stall.
// After reset a pass over all cells clears the cell sums while busy is high.
// Reset is synchronous and restores the configuration reset values.
module point_cloud_grid_height_average import pcgh_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,
  input  logic                      start,
  output logic                      busy,
  input  logic                      kind,
  input  logic signed [COORD_W-1:0] x_coord,
  input  logic signed [COORD_W-1:0] height_coord,
  input  logic signed [COORD_W-1:0] z_coord,
  output logic                      result_valid,
  output logic [CELL_AW-1:0]        cell_index,
  output logic signed [AVG_W-1:0]   average_height,
  output logic                      cell_empty,
  output logic                      last_cell
);

  state_t state;

  logic signed [CFG_W-1:0]   grid_x_low, grid_x_high, grid_z_low, grid_z_high;
  logic signed [CFG_W-1:0]   height_low, height_high;
  logic [STEP_W-1:0]         cell_step;
  logic [STEP_W-1:0]         step_eff;

  logic [CNT_W-1:0]          point_count;
  logic [CNT_W-1:0]          idx;
  logic signed [COORD_W-1:0] axis_min [3];
  logic signed [COORD_W-1:0] axis_max [3];
  logic signed [COORD_W-1:0] pin [3];

  logic [PT_DW-1:0]          pt;
  logic [1:0]                axis;
  logic signed [PROD_W-1:0]  prod;
  logic signed [Q_W-1:0]     qx, qz;
  logic signed [NH_W-1:0]    nh;
  logic [CELL_AW-1:0]        col, row, k;
  logic [GRID_W-1:0]         cols, rows_raw, rows, total;
  logic                      div_go;

  logic signed [COORD_W-1:0] sel_p, sel_mn, sel_mx;
  logic signed [CFG_W-1:0]   sel_lo, sel_hi;
  logic signed [COORD_W:0]   diff, span;
  logic signed [SPAN_W-1:0]  range_w;
  logic signed [Q_W-1:0]     q_now;
  logic [GRID_W-1:0]         row_lim;
  logic [GRID_W-1:0]         rows_min;
  logic [CELL_AW-1:0]        cell_addr;
  logic [2*GRID_W-1:0]       cell_mac;
  logic signed [SUM_W-1:0]   rd_sum;
  logic [CNT_W-1:0]          rd_cnt;
  logic                      load_ok;

  logic                      pt_we;
  logic [PT_AW-1:0]          pt_addr;
  logic [PT_DW-1:0]          pt_rdata;
  logic                      cell_we;
  logic [CELL_DW-1:0]        cell_wdata, cell_rdata;

  div_req_t                  div_req;
  div_rsp_t                  div_rsp;

  function automatic logic [GRID_W-1:0] clamp_cells(logic signed [DIV_NW-1:0] q);
    logic [GRID_W-1:0] r;
    if (q[DIV_NW-1] || q == '0) begin
      r = GRID_W'(1);
    end else if ($unsigned(q) > DIV_NW'(GRID_CELLS)) begin
      r = GRID_W'(GRID_CELLS);
    end else begin
      r = q[GRID_W-1:0];
    end
    return r;
  endfunction

  assign busy     = (state != S_IDLE) || rst;
  assign step_eff = (cell_step == '0) ? STEP_W'(1) : cell_step;
  assign pin[0]   = x_coord;
  assign pin[1]   = height_coord;
  assign pin[2]   = z_coord;
  assign load_ok  = (state == S_IDLE) && start && !rst && !kind &&
                    (point_count != CNT_W'(MAX_POINTS));

  always_comb begin
    case (axis)
      2'd0: begin
        sel_p = pt[PT_DW-1 -: COORD_W]; sel_lo = grid_x_low; sel_hi = grid_x_high;
      end
      2'd1: begin
        sel_p = pt[2*COORD_W-1 -: COORD_W]; sel_lo = height_low; sel_hi = height_high;
      end
      default: begin
        sel_p = pt[COORD_W-1:0]; sel_lo = grid_z_low; sel_hi = grid_z_high;
      end
    endcase
    sel_mn = (axis == 2'd0) ? axis_min[0] : (axis == 2'd1) ? axis_min[1] : axis_min[2];
    sel_mx = (axis == 2'd0) ? axis_max[0] : (axis == 2'd1) ? axis_max[1] : axis_max[2];
  end

  assign diff     = (COORD_W+1)'(sel_p) - (COORD_W+1)'(sel_mn);
  assign span     = (COORD_W+1)'(sel_mx) - (COORD_W+1)'(sel_mn);
  assign range_w  = SPAN_W'(sel_hi) - SPAN_W'(sel_lo);
  assign q_now    = div_rsp.quotient[Q_W-1:0];
  assign row_lim  = div_rsp.quotient[GRID_W-1:0];
  assign rows_min = (rows_raw > row_lim) ? row_lim : rows_raw;
  assign cell_mac = (2*GRID_W)'(row) * (2*GRID_W)'(cols) + (2*GRID_W)'(col);
  assign cell_addr = cell_mac[CELL_AW-1:0];
  assign rd_sum   = cell_rdata[CELL_DW-1:CNT_W];
  assign rd_cnt   = cell_rdata[CNT_W-1:0];

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = '0;
    div_req.divisor  = DIV_DW'(step_eff);
    case (state)
      S_COLS: begin
        div_req.start    = !div_go;
        div_req.dividend = DIV_NW'(SPAN_W'(grid_x_high) - SPAN_W'(grid_x_low));
      end
      S_ROWS: begin
        div_req.start    = !div_go;
        div_req.dividend = DIV_NW'(SPAN_W'(grid_z_high) - SPAN_W'(grid_z_low));
      end
      S_RCLAMP: begin
        div_req.start    = !div_go;
        div_req.dividend = DIV_NW'(GRID_CELLS);
        div_req.divisor  = DIV_DW'(cols);
      end
      S_NDIV: begin
        div_req.start    = !div_go;
        div_req.dividend = DIV_NW'($signed({prod, 8'h00}));
        div_req.divisor  = span[DIV_DW-1:0];
      end
      S_BINX: begin
        div_req.start    = !div_go && !qx[Q_W-1];
        div_req.dividend = DIV_NW'(qx >>> 8);
      end
      S_BINZ: begin
        div_req.start    = !div_go && !qz[Q_W-1];
        div_req.dividend = DIV_NW'(qz >>> 8);
      end
      S_EMIT_DIV: begin
        div_req.start    = !div_go && (rd_cnt != '0);
        div_req.dividend = DIV_NW'(rd_sum);
        div_req.divisor  = DIV_DW'(rd_cnt);
      end
      default: begin
        div_req.start = 1'b0;
      end
    endcase
  end

  always_comb begin
    pt_we   = load_ok;
    pt_addr = (state == S_IDLE) ? point_count[PT_AW-1:0] : idx[PT_AW-1:0];
  end

  always_comb begin
    cell_we    = 1'b0;
    cell_wdata = '0;
    case (state)
      S_CLEAR: cell_we = 1'b1;
      S_ACC_WRITE: begin
        cell_we    = 1'b1;
        cell_wdata = {rd_sum + SUM_W'(nh), rd_cnt + 1'b1};
      end
      S_EMIT_DIV: cell_we = (div_go && div_rsp.done) || (!div_go && rd_cnt == '0);
      default: cell_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_x_low  <= -CFG_W'(100);
      grid_x_high <= CFG_W'(100);
      grid_z_low  <= -CFG_W'(100);
      grid_z_high <= CFG_W'(100);
      height_low  <= CFG_W'(0);
      height_high <= CFG_W'(10);
      cell_step   <= STEP_W'(25);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GRID_X_LOW:  grid_x_low  <= cfg_data;
        CFG_GRID_X_HIGH: grid_x_high <= cfg_data;
        CFG_GRID_Z_LOW:  grid_z_low  <= cfg_data;
        CFG_GRID_Z_HIGH: grid_z_high <= cfg_data;
        CFG_HEIGHT_LOW:  height_low  <= cfg_data;
        CFG_HEIGHT_HIGH: height_high <= cfg_data;
        CFG_CELL_STEP:   cell_step   <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      point_count  <= '0;
      k            <= '0;
      div_go       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (div_req.start) begin
        div_go <= 1'b1;
      end
      case (state)
        S_CLEAR: begin
          k <= k + 1'b1;
          if (k == CELL_AW'(GRID_CELLS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          k <= '0;
          if (load_ok) begin
            for (int a = 0; a < 3; a++) begin
              if (point_count == '0 || pin[a] < axis_min[a]) axis_min[a] <= pin[a];
              if (point_count == '0 || pin[a] > axis_max[a]) axis_max[a] <= pin[a];
            end
            point_count <= point_count + 1'b1;
          end else if (start && kind) begin
            state <= S_COLS;
          end
        end
        S_COLS: begin
          if (div_go && div_rsp.done) begin
            div_go <= 1'b0;
            cols   <= clamp_cells(div_rsp.quotient);
            state  <= S_ROWS;
          end
        end
        S_ROWS: begin
          if (div_go && div_rsp.done) begin
            div_go   <= 1'b0;
            rows_raw <= clamp_cells(div_rsp.quotient);
            state    <= S_RCLAMP;
          end
        end
        S_RCLAMP: begin
          if (div_go && div_rsp.done) begin
            div_go <= 1'b0;
            rows   <= rows_min;
            total  <= GRID_W'((2*GRID_W)'(cols) * (2*GRID_W)'(rows_min));
            idx    <= '0;
            state  <= (point_count == '0) ? S_EMIT_READ : S_PT_READ;
          end
        end
        S_PT_READ: state <= S_PT_LATCH;
        S_PT_LATCH: begin
          pt    <= pt_rdata;
          axis  <= 2'd0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (sel_mx == sel_mn) begin
            case (axis)
              2'd0:    qx <= '0;
              2'd1:    nh <= NH_W'(sel_lo) <<< 8;
              default: qz <= '0;
            endcase
            axis  <= axis + 1'b1;
            state <= (axis == 2'd2) ? S_BINX : S_MUL;
          end else begin
            prod  <= PROD_W'(diff) * PROD_W'(range_w);
            state <= S_NDIV;
          end
        end
        S_NDIV: begin
          if (div_go && div_rsp.done) begin
            div_go <= 1'b0;
            case (axis)
              2'd0:    qx <= q_now;
              2'd1:    nh <= (NH_W'(sel_lo) <<< 8) + NH_W'(q_now);
              default: qz <= q_now;
            endcase
            axis  <= axis + 1'b1;
            state <= (axis == 2'd2) ? S_BINX : S_MUL;
          end
        end
        S_BINX: begin
          if (!div_go && qx[Q_W-1]) begin
            col   <= '0;
            state <= S_BINZ;
          end else if (div_go && div_rsp.done) begin
            div_go <= 1'b0;
            if ($unsigned(div_rsp.quotient) >= DIV_NW'(cols)) begin
              col <= CELL_AW'(cols - 1'b1);
            end else begin
              col <= div_rsp.quotient[CELL_AW-1:0];
            end
            state <= S_BINZ;
          end
        end
        S_BINZ: begin
          if (!div_go && qz[Q_W-1]) begin
            row   <= '0;
            state <= S_ACC_READ;
          end else if (div_go && div_rsp.done) begin
            div_go <= 1'b0;
            if ($unsigned(div_rsp.quotient) >= DIV_NW'(rows)) begin
              row <= CELL_AW'(rows - 1'b1);
            end else begin
              row <= div_rsp.quotient[CELL_AW-1:0];
            end
            state <= S_ACC_READ;
          end
        end
        S_ACC_READ: state <= S_ACC_WRITE;
        S_ACC_WRITE: begin
          idx   <= idx + 1'b1;
          state <= (idx + 1'b1 == point_count) ? S_EMIT_READ : S_PT_READ;
        end
        S_EMIT_READ: state <= S_EMIT_DIV;
        S_EMIT_DIV: begin
          if (cell_we) begin
            div_go         <= 1'b0;
            result_valid   <= 1'b1;
            cell_index     <= k;
            cell_empty     <= (rd_cnt == '0);
            average_height <= (rd_cnt == '0) ? '0 : div_rsp.quotient[AVG_W-1:0];
            last_cell      <= ({1'b0, k} == total - 1'b1);
            if ({1'b0, k} == total - 1'b1) begin
              point_count <= '0;
              k           <= '0;
              state       <= S_IDLE;
            end else begin
              k     <= k + 1'b1;
              state <= S_EMIT_READ;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  pcgh_ram #(.WIDTH(PT_DW), .DEPTH(MAX_POINTS)) u_point_ram (
    .clk   (clk),
    .we    (pt_we),
    .addr  (pt_addr),
    .wdata ({x_coord, height_coord, z_coord}),
    .rdata (pt_rdata)
  );

  pcgh_ram #(.WIDTH(CELL_DW), .DEPTH(GRID_CELLS)) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .addr  ((state == S_ACC_READ || state == S_ACC_WRITE) ? cell_addr : k),
    .wdata (cell_wdata),
    .rdata (cell_rdata)
  );

  pcgh_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

// ----- src/pcgh_checker.sv -----
// Port-level checks of the point cloud height grid, bound to the top level.
module pcgh_checker import pcgh_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      cfg_write,
  input logic [CFG_IDX_W-1:0]      cfg_index,
  input logic [CFG_W-1:0]          cfg_data,
  input logic                      start,
  input logic                      busy,
  input logic                      kind,
  input logic signed [COORD_W-1:0] x_coord,
  input logic signed [COORD_W-1:0] height_coord,
  input logic signed [COORD_W-1:0] z_coord,
  input logic                      result_valid,
  input logic [CELL_AW-1:0]        cell_index,
  input logic signed [AVG_W-1:0]   average_height,
  input logic                      cell_empty,
  input logic                      last_cell
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_valid && busy)
    else $error("result or idle right after reset");

  a_word_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result words back to back");

  a_busy_emit: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last_cell |-> busy)
    else $error("block idle in the middle of a run");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && cell_empty |-> average_height == '0)
    else $error("empty cell with nonzero average");

endmodule

bind point_cloud_grid_height_average pcgh_checker u_pcgh_checker (.*);

// ----- tb/sv/tb_point_cloud_grid_height_average.sv -----
// Self-checking testbench for the point cloud height grid average block.
module tb_point_cloud_grid_height_average;
  import pcgh_pkg::*;

  localparam longint CYCLE_LIMIT = 10000000;

  typedef struct packed {
    logic [CELL_AW-1:0]      index;
    logic signed [AVG_W-1:0] average;
    logic                    empty;
    logic                    last;
  } cell_word_t;

  typedef struct {
    logic        kind;
    logic [31:0] x;
    logic [31:0] h;
    logic [31:0] z;
    bit          all_empty;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic start = 1'b0;
  logic busy;
  logic kind = 1'b0;
  logic signed [COORD_W-1:0] x_coord = '0;
  logic signed [COORD_W-1:0] height_coord = '0;
  logic signed [COORD_W-1:0] z_coord = '0;
  logic result_valid;
  logic [CELL_AW-1:0] cell_index;
  logic signed [AVG_W-1:0] average_height;
  logic cell_empty;
  logic last_cell;

  point_cloud_grid_height_average u_top (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  cell_word_t pending_cells[$];
  int mismatches = 0;
  longint cycles = 0;

  longint reg_x_low = -100, reg_x_high = 100, reg_z_low = -100, reg_z_high = 100;
  longint reg_h_low = 0, reg_h_high = 10, reg_step = 25;

  longint pts_x[$], pts_h[$], pts_z[$];
  longint axis_min[3], axis_max[3];

  function automatic longint normalize(longint p, longint mn, longint mx,
                                       longint lo, longint hi);
    if (mx == mn) return lo * 256;
    return lo * 256 + ((p - mn) * (hi - lo) * 256) / (mx - mn);
  endfunction

  function automatic longint cells_along(longint lo, longint hi, longint step);
    longint n;
    n = (hi - lo > 0) ? (hi - lo) / step : 0;
    return (n < 1) ? 1 : n;
  endfunction

  function automatic longint bin_of(longint n, longint lo, longint step, longint cnt);
    longint off, c;
    off = n - lo * 256;
    if (off < 0) return 0;
    c = off / (step * 256);
    return (c > cnt - 1) ? cnt - 1 : c;
  endfunction

  function automatic longint sext12(logic [CFG_W-1:0] v);
    return longint'($signed(v));
  endfunction

  task automatic apply_register(cfg_index_t idx, logic [CFG_W-1:0] v);
    case (idx)
      CFG_GRID_X_LOW:  reg_x_low = sext12(v);
      CFG_GRID_X_HIGH: reg_x_high = sext12(v);
      CFG_GRID_Z_LOW:  reg_z_low = sext12(v);
      CFG_GRID_Z_HIGH: reg_z_high = sext12(v);
      CFG_HEIGHT_LOW:  reg_h_low = sext12(v);
      CFG_HEIGHT_HIGH: reg_h_high = sext12(v);
      CFG_CELL_STEP:   reg_step = longint'(v[STEP_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic grid_accept(logic k, logic [31:0] x, logic [31:0] h, logic [31:0] z,
                             bit push_words);
    longint p[3];
    longint step, cols, rows, total, nx, nh, nz, cell_num, avg;
    longint sums[GRID_CELLS];
    int counts[GRID_CELLS];
    cell_word_t w;
    if (k == 1'b0) begin
      if (pts_x.size() >= MAX_POINTS) return;
      p[0] = longint'($signed(x));
      p[1] = longint'($signed(h));
      p[2] = longint'($signed(z));
      for (int a = 0; a < 3; a++) begin
        if (pts_x.size() == 0 || p[a] < axis_min[a]) axis_min[a] = p[a];
        if (pts_x.size() == 0 || p[a] > axis_max[a]) axis_max[a] = p[a];
      end
      pts_x = {pts_x, p[0]};
      pts_h = {pts_h, p[1]};
      pts_z = {pts_z, p[2]};
      return;
    end
    step = (reg_step == 0) ? 1 : reg_step;
    cols = cells_along(reg_x_low, reg_x_high, step);
    if (cols > GRID_CELLS) cols = GRID_CELLS;
    rows = cells_along(reg_z_low, reg_z_high, step);
    if (rows > GRID_CELLS / cols) rows = GRID_CELLS / cols;
    total = cols * rows;
    for (int c = 0; c < GRID_CELLS; c++) begin
      sums[c] = 0;
      counts[c] = 0;
    end
    for (int i = 0; i < pts_x.size(); i++) begin
      nx = normalize(pts_x[i], axis_min[0], axis_max[0], reg_x_low, reg_x_high);
      nh = normalize(pts_h[i], axis_min[1], axis_max[1], reg_h_low, reg_h_high);
      nz = normalize(pts_z[i], axis_min[2], axis_max[2], reg_z_low, reg_z_high);
      cell_num = bin_of(nz, reg_z_low, step, rows) * cols + bin_of(nx, reg_x_low, step, cols);
      if (cell_num >= 0 && cell_num < GRID_CELLS) begin
        sums[cell_num] += nh;
        counts[cell_num]++;
      end
    end
    for (int c = 0; c < total; c++) begin
      avg = (counts[c] == 0) ? 0 : sums[c] / counts[c];
      w.index = c[CELL_AW-1:0];
      w.average = avg[AVG_W-1:0];
      w.empty = (counts[c] == 0);
      w.last = (c == total - 1);
      if (push_words) pending_cells = {pending_cells, w};
    end
    pts_x.delete();
    pts_h.delete();
    pts_z.delete();
  endtask

  always @(posedge clk) begin
    cell_word_t got, want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("point_cloud_grid_height_average: mismatch");
      $finish;
    end
    if (!rst && result_valid) begin
      got = '{cell_index, average_height, cell_empty, last_cell};
      if (pending_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word %p.", got);
      end else begin
        want = pending_cells.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Expected %p, got %p.", want, got);
        end
      end
    end
  end

  task automatic send_word(logic k, logic [31:0] x, logic [31:0] h, logic [31:0] z,
                           int idle_pct, bit typed_empty);
    cell_word_t w;
    @(negedge clk);
    start <= 1'b1;
    kind <= k;
    x_coord <= x;
    height_coord <= h;
    z_coord <= z;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    if (typed_empty) begin
      grid_accept(k, x, h, z, 1'b0);
      for (int c = 0; c < 64; c++) begin
        w = '{c[CELL_AW-1:0], '0, 1'b1, c == 63};
        pending_cells = {pending_cells, w};
      end
    end else begin
      grid_accept(k, x, h, z, 1'b1);
    end
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic settle;
    @(negedge clk);
    start <= 1'b0;
    wait (pending_cells.size() == 0);
    repeat (200) @(posedge clk);
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
  endtask

  task automatic write_settings(logic [CFG_W-1:0] vals[7]);
    settle();
    @(negedge clk);
    start <= 1'b0;
    for (int r = 0; r < 7; r++) begin
      cfg_write <= 1'b1;
      cfg_index <= cfg_index_t'(r);
      cfg_data <= vals[r];
      @(posedge clk);
      apply_register(cfg_index_t'(r), vals[r]);
      @(negedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic logic [31:0] random_coord(int style);
    case (style)
      0: return $urandom;
      1: return 32'($signed($urandom_range(8000)) - 4000);
      default: return 32'($signed($urandom_range(400000)) - 200000);
    endcase
  endfunction

  stim_row_t directed[] = '{
    '{1'b1, 32'h0, 32'h0, 32'h0, 1'b1},
    '{1'b0, 32'h0000_0100, 32'h0000_0200, 32'h0000_0300, 1'b0},
    '{1'b1, 32'h0, 32'h0, 32'h0, 1'b0},
    '{1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0},
    '{1'b0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0},
    '{1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
    '{1'b0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF, 1'b0},
    '{1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FF00, 1'b0},
    '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0},
    '{1'b0, 32'h0000_1000, 32'h5555_5555, 32'h0000_1000, 1'b0},
    '{1'b0, 32'h0000_1000, 32'hAAAA_AAAA, 32'h0000_1000, 1'b0},
    '{1'b1, 32'h0, 32'h0, 32'h0, 1'b0},
    '{1'b1, 32'h0, 32'h0, 32'h0, 1'b1}
  };

  logic [CFG_W-1:0] settings[6][7] = '{
    '{-12'sd1024, 12'sd1024, -12'sd1024, 12'sd1024, -12'sd1024, 12'sd1024, 12'd1024},
    '{-12'sd1024, 12'sd1024, 12'sd0, 12'sd0, -12'sd5, 12'sd5, 12'd0},
    '{12'sd50, -12'sd50, -12'sd3, 12'sd40, 12'sd1024, -12'sd1024, 12'd7},
    '{-12'sd100, 12'sd100, -12'sd100, 12'sd100, 12'sd0, 12'sd10, 12'd25},
    '{12'sd0, 12'sd20, 12'sd0, 12'sd10, -12'sd1, 12'sd1, 12'd2047},
    '{-12'sd30, 12'sd30, -12'sd20, 12'sd20, 12'sd0, 12'sd100, 12'd3}
  };

  initial begin
    int idle_pct, style, run_len;
    logic [CFG_W-1:0] vals[7];
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (directed[i])
      send_word(directed[i].kind, directed[i].x, directed[i].h, directed[i].z,
                0, directed[i].all_empty);
    for (int ph = 0; ph < 6; ph++) begin
      vals = settings[ph];
      write_settings(vals);
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 68;
        2: idle_pct = 0;
        default: idle_pct = 31;
      endcase
      for (int n = 0; n < 45; ) begin
        run_len = ($urandom_range(5) == 0) ? $urandom_range(2) : $urandom_range(3, 14);
        style = $urandom_range(2);
        for (int j = 0; j < run_len; j++) begin
          send_word(1'b0, random_coord(style), random_coord(style), random_coord(style),
                    idle_pct, 1'b0);
          n++;
        end
        send_word(1'b1, $urandom, $urandom, $urandom, idle_pct, 1'b0);
        n++;
      end
    end
    @(negedge clk);
    start <= 1'b0;
    wait (pending_cells.size() == 0);
    repeat (300) @(posedge clk);
    if (mismatches == 0 && pending_cells.size() == 0) begin
      $display("point_cloud_grid_height_average: match");
    end else begin
      $display("point_cloud_grid_height_average: mismatch");
    end
    $finish;
  end

endmodule
